FILE: rtl/rca_pkg.sv
// Shared types, widths and constants of the Rosenbrock cost accumulator.
// Used by every RTL module and by the port checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rca_pkg;

    localparam int COORD_W     = 16;
    localparam int SUM_W       = 56;
    localparam int OUT_W       = 56;
    localparam int BOUND_W     = 15;
    localparam logic [BOUND_W-1:0] BOUND_RESET = BOUND_W'(7680);

    localparam int FRAC_SH     = 8;
    localparam int ROUND_SH    = 16;
    localparam int ONE_Q       = 256;
    localparam int COST_SCALE  = 100;

    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam int CMP_W  = ((COORD_W > BOUND_W) ? COORD_W : BOUND_W + 1) + 1;
    localparam int PSQ_W  = 2 * COORD_W;
    localparam int XS_W   = COORD_W + FRAC_SH;
    localparam int E_W    = 2 * COORD_W + 2;
    localparam int MAG_W  = 32;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int R_W    = SQ_W - ROUND_SH + 1;
    localparam int R100_W = R_W + 7;
    localparam int D_W    = COORD_W + 1;
    localparam int D2_W   = 2 * D_W;
    localparam int TERM_W = ((R100_W > D2_W) ? R100_W : D2_W) + 1;
    localparam int ACC_W  = ((TERM_W > SUM_W) ? TERM_W : SUM_W) + 1;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [E_W-1:0]   MAG_LIM = E_W'({MAG_W{1'b1}});

    typedef struct packed {
        logic                      pair;
        logic                      last;
        logic                      viol;
        logic signed [COORD_W-1:0] p;
        logic signed [COORD_W-1:0] x;
    } t_cmd;

    typedef struct packed {
        logic vld;
        logic pair;
        logic last;
        logic viol;
        logic ovf;
    } t_ctl;

endpackage

`default_nettype wire

FILE: rtl/rosenbrock_cost_accumulator.sv
// Rosenbrock cost accumulator: front end, command queue and back end.
// Takes one coordinate word per cycle while not stalled; the result word is registered.
// Throughput is set by the output register: the pipeline holds while a result is stalled,
// and the 4-entry queue absorbs input for that time.
// Synchronous active-low reset clears all vector state, sets the bound to 30.0.
// Depends on rca_pkg, rca_front, rca_queue and rca_back.
`timescale 1ns / 1ps
`default_nettype none

module rosenbrock_cost_accumulator (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic signed [rca_pkg::COORD_W-1:0] i_coord_value,
    input  wire logic                               i_last_element,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [rca_pkg::OUT_W-1:0]               o_cost_sum,
    output logic                                    o_out_of_range,
    output logic                                    o_saturated,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [rca_pkg::BOUND_W-1:0]        i_cfg_data
);

    rca_pkg::t_cmd push_cmd;
    rca_pkg::t_cmd head_cmd;
    logic          push;
    logic          pop;
    logic          q_empty;
    logic          q_full;

    assign o_in_stall  = q_full;
    assign o_cfg_ready = 1'b1;

    rca_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_coord_value  (i_coord_value),
        .i_last_element (i_last_element),
        .i_full         (q_full),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    rca_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    rca_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (head_cmd),
        .i_empty        (q_empty),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_cost_sum     (o_cost_sum),
        .o_out_of_range (o_out_of_range),
        .o_saturated    (o_saturated)
    );

endmodule

`default_nettype wire

FILE: rtl/rca_front.sv
// Front end: accepts coordinate words, checks the bound and pairs each word
// with its predecessor into commands. Depends on rca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rca_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    input  wire logic signed [rca_pkg::COORD_W-1:0] i_coord_value,
    input  wire logic                               i_last_element,
    input  wire logic                               i_full,
    input  wire logic                               i_cfg_valid,
    input  wire logic [rca_pkg::BOUND_W-1:0]        i_cfg_data,
    output logic                                    o_push,
    output rca_pkg::t_cmd                           o_cmd
);

    logic [rca_pkg::BOUND_W-1:0]        r_bound;
    logic signed [rca_pkg::COORD_W-1:0] r_prev;
    logic                               r_have;
    logic                               r_viol;

    logic                               accept;
    logic signed [rca_pkg::CMP_W-1:0]   x_ext;
    logic signed [rca_pkg::CMP_W-1:0]   lim_ext;
    logic                               oor;

    assign accept  = i_in_valid && !i_full;
    assign x_ext   = rca_pkg::CMP_W'(i_coord_value);
    assign lim_ext = $signed(rca_pkg::CMP_W'(r_bound));
    assign oor     = (x_ext < -lim_ext) || (x_ext > lim_ext);

    always_comb begin
        o_cmd.pair = r_have && !r_viol;
        o_cmd.last = i_last_element;
        o_cmd.viol = r_viol;
        o_cmd.p    = r_prev;
        o_cmd.x    = i_coord_value;
    end

    assign o_push = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound <= rca_pkg::BOUND_RESET;
            r_prev  <= '0;
            r_have  <= 1'b0;
            r_viol  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_bound <= i_cfg_data;
            end
            if (accept) begin
                if (i_last_element) begin
                    r_prev <= '0;
                    r_have <= 1'b0;
                    r_viol <= 1'b0;
                end else begin
                    r_prev <= i_coord_value;
                    r_have <= 1'b1;
                    r_viol <= r_viol | oor;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rca_queue.sv
// Short command queue between front and back end.
// Depends on rca_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none

module rca_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  rca_pkg::t_cmd       i_cmd,
    input  wire logic           i_pop,
    output rca_pkg::t_cmd       o_cmd,
    output logic                o_empty,
    output logic                o_full
);

    rca_pkg::t_cmd                  r_mem [rca_pkg::QDEPTH];
    logic [rca_pkg::QPTR_W-1:0]     r_wr;
    logic [rca_pkg::QPTR_W-1:0]     r_rd;
    logic [rca_pkg::QCNT_W-1:0]     r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == rca_pkg::QCNT_W'(rca_pkg::QDEPTH));
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + rca_pkg::QCNT_W'(i_push) - rca_pkg::QCNT_W'(i_pop);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rca_back.sv
// Back end: five-stage pair-term pipeline, saturating accumulator and the
// result output register. Depends on rca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rca_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  rca_pkg::t_cmd                   i_cmd,
    input  wire logic                       i_empty,
    output logic                            o_pop,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [rca_pkg::OUT_W-1:0]       o_cost_sum,
    output logic                            o_out_of_range,
    output logic                            o_saturated
);

    logic en;

    // stage 1
    rca_pkg::t_ctl                      r1_ctl;
    logic signed [rca_pkg::PSQ_W-1:0]   r1_psq;
    logic signed [rca_pkg::XS_W-1:0]    r1_xs;
    logic [rca_pkg::D_W-1:0]            r1_d;
    logic signed [rca_pkg::PSQ_W-1:0]   n1_psq;
    logic signed [rca_pkg::D_W:0]       n1_ds;
    logic [rca_pkg::D_W-1:0]            n1_d;

    // stage 2
    rca_pkg::t_ctl                      r2_ctl;
    logic [rca_pkg::MAG_W-1:0]          r2_m;
    logic [rca_pkg::D2_W-1:0]           r2_d2;
    logic signed [rca_pkg::E_W-1:0]     n2_e;
    logic [rca_pkg::E_W-1:0]            n2_mag;

    // stage 3
    rca_pkg::t_ctl                      r3_ctl;
    logic [rca_pkg::SQ_W-1:0]           r3_sq;
    logic [rca_pkg::D2_W-1:0]           r3_d2;

    // stage 4
    rca_pkg::t_ctl                      r4_ctl;
    logic [rca_pkg::R100_W-1:0]         r4_r100;
    logic [rca_pkg::D2_W-1:0]           r4_d2;
    logic [rca_pkg::R_W-1:0]            n4_r;

    // stage 5
    rca_pkg::t_ctl                      r5_ctl;
    logic [rca_pkg::TERM_W-1:0]         r5_term;

    // accumulator
    logic [rca_pkg::SUM_W-1:0]          r_sum;
    logic                               r_clip;
    logic [rca_pkg::SUM_W-1:0]          n_sum;
    logic                               n_clip;
    logic [rca_pkg::ACC_W-1:0]          acc;

    logic                               r_out_valid;
    logic [rca_pkg::OUT_W-1:0]          r_cost;
    logic                               r_oor;
    logic                               r_sat;

    assign en    = !(r_out_valid && i_out_stall);
    assign o_pop = en && !i_empty;

    always_comb begin
        n1_psq = i_cmd.p * i_cmd.p;
        n1_ds  = $signed((rca_pkg::D_W + 1)'(rca_pkg::ONE_Q))
               - (rca_pkg::D_W + 1)'(i_cmd.p);
        n1_d   = n1_ds[rca_pkg::D_W] ? rca_pkg::D_W'(-n1_ds) : rca_pkg::D_W'(n1_ds);
    end

    always_comb begin
        n2_e   = rca_pkg::E_W'(r1_xs) - rca_pkg::E_W'(r1_psq);
        n2_mag = n2_e[rca_pkg::E_W-1] ? rca_pkg::E_W'(-n2_e) : rca_pkg::E_W'(n2_e);
    end

    assign n4_r = rca_pkg::R_W'(r3_sq >> rca_pkg::ROUND_SH)
                + rca_pkg::R_W'(r3_sq[rca_pkg::ROUND_SH-1]);

    always_comb begin
        acc    = rca_pkg::ACC_W'(r_sum) + rca_pkg::ACC_W'(r5_term);
        n_sum  = r_sum;
        n_clip = r_clip;
        if (r5_ctl.vld && r5_ctl.pair) begin
            if (r5_ctl.ovf || (acc > rca_pkg::ACC_W'(rca_pkg::SUM_MAX))) begin
                n_sum  = rca_pkg::SUM_MAX;
                n_clip = 1'b1;
            end else begin
                n_sum  = rca_pkg::SUM_W'(acc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_psq  <= n1_psq;
            r1_xs   <= rca_pkg::XS_W'(i_cmd.x) <<< rca_pkg::FRAC_SH;
            r1_d    <= n1_d;
            r2_m    <= rca_pkg::MAG_W'(n2_mag);
            r2_d2   <= r1_d * r1_d;
            r3_sq   <= r2_m * r2_m;
            r3_d2   <= r2_d2;
            r4_r100 <= rca_pkg::R100_W'(n4_r) * rca_pkg::R100_W'(rca_pkg::COST_SCALE);
            r4_d2   <= r3_d2;
            r5_term <= rca_pkg::TERM_W'(r4_r100) + rca_pkg::TERM_W'(r4_d2);
            if (r5_ctl.vld && r5_ctl.last) begin
                r_cost <= r5_ctl.viol ? '0 : rca_pkg::OUT_W'(n_sum);
                r_oor  <= r5_ctl.viol;
                r_sat  <= r5_ctl.viol ? 1'b0 : n_clip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl      <= '0;
            r2_ctl      <= '0;
            r3_ctl      <= '0;
            r4_ctl      <= '0;
            r5_ctl      <= '0;
            r_sum       <= '0;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r1_ctl.vld  <= !i_empty;
            r1_ctl.pair <= i_cmd.pair;
            r1_ctl.last <= i_cmd.last;
            r1_ctl.viol <= i_cmd.viol;
            r1_ctl.ovf  <= 1'b0;
            r2_ctl.vld  <= r1_ctl.vld;
            r2_ctl.pair <= r1_ctl.pair;
            r2_ctl.last <= r1_ctl.last;
            r2_ctl.viol <= r1_ctl.viol;
            r2_ctl.ovf  <= n2_mag > rca_pkg::MAG_LIM;
            r3_ctl      <= r2_ctl;
            r4_ctl      <= r3_ctl;
            r5_ctl      <= r4_ctl;
            r_out_valid <= r5_ctl.vld && r5_ctl.last;
            if (r5_ctl.vld && r5_ctl.last) begin
                r_sum  <= '0;
                r_clip <= 1'b0;
            end else begin
                r_sum  <= n_sum;
                r_clip <= n_clip;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_cost_sum     = r_cost;
    assign o_out_of_range = r_oor;
    assign o_saturated    = r_sat;

endmodule

`default_nettype wire

FILE: rtl/rca_checker.sv
// Port-level checker for the Rosenbrock cost accumulator, bound to the top.
// Depends on rca_pkg and rosenbrock_cost_accumulator.
`timescale 1ns / 1ps
`default_nettype none

module rca_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    input  wire logic                               o_in_stall,
    input  wire logic signed [rca_pkg::COORD_W-1:0] i_coord_value,
    input  wire logic                               i_last_element,
    input  wire logic                               o_out_valid,
    input  wire logic                               i_out_stall,
    input  wire logic [rca_pkg::OUT_W-1:0]          o_cost_sum,
    input  wire logic                               o_out_of_range,
    input  wire logic                               o_saturated
);

    a_oor_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_of_range) |-> (o_cost_sum == '0) && !o_saturated)
        else $error("out-of-range word carries a cost or saturation flag");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |-> (o_cost_sum == rca_pkg::OUT_W'(rca_pkg::SUM_MAX)))
        else $error("saturated word is not at full scale");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid && $stable(o_cost_sum)
            && $stable(o_out_of_range) && $stable(o_saturated))
        else $error("stalled result word changed");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> i_in_valid && $stable(i_coord_value)
            && $stable(i_last_element))
        else $error("stalled input word changed");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid right after reset");

endmodule

bind rosenbrock_cost_accumulator rca_checker u_chk (.*);

`default_nettype wire
